/* hw/rtl/swmm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the sliding window min/max logger
package swmm_pkg;

	localparam int TEMP_W     = 11;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = INTERVAL_W'(1000);
	localparam logic [TEMP_W-1:0]     THRESHOLD_RST = TEMP_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_INTERVAL = 2'd0,
		CFG_BURNER_THRESH   = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              read_ok;
		logic [TEMP_W-1:0] temperature;
		logic              clear_peak;
	} in_item_t;

	typedef struct packed {
		logic              sample_taken;
		logic              burner_active;
		logic [TEMP_W-1:0] latest_temp;
		logic [TEMP_W-1:0] window_max;
		logic [TEMP_W-1:0] window_min;
		logic [TEMP_W-1:0] peak_temp;
	} out_item_t;

	// running extremes handed from cell to cell
	typedef struct packed {
		logic [TEMP_W-1:0] lo;
		logic [TEMP_W-1:0] hi;
	} link_t;

endpackage

/* hw/rtl/swmm_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready stream channel with a typed payload
interface swmm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/swmm_cfg_if.sv */
`timescale 1ns / 1ps
// configuration write channel with register index and data
interface swmm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swmm_pkg::CFG_IDX_W-1:0]  idx;
	logic [swmm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

/* hw/rtl/swmm_cell.sv */
`timescale 1ns / 1ps
// one history cell: holds an entry and folds it into the passing min/max
module swmm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift_en,
	input  logic [swmm_pkg::TEMP_W-1:0] entry_in,
	input  swmm_pkg::link_t             link_in,
	output logic [swmm_pkg::TEMP_W-1:0] entry_q,
	output swmm_pkg::link_t             link_q
);

	// history entry, shifts toward the older end on a taken sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en) begin
			entry_q <= entry_in;
		end
	end

	// running extremes move one cell per cycle
	always_ff @(posedge clk) begin
		link_q.lo <= (entry_q < link_in.lo) ? entry_q : link_in.lo;
		link_q.hi <= (entry_q > link_in.hi) ? entry_q : link_in.hi;
	end

endmodule

/* hw/rtl/sliding_window_min_max_logger.sv */
`timescale 1ns / 1ps
// top level of the sliding window min/max temperature logger
//
// Usage: items arrive on the samples channel (time stamp, read flag,
// temperature, peak clear) and each one yields exactly one result on the
// results channel. Registers are written over cfg (index 0 sample interval,
// index 1 burner threshold); the user must write them only while the block
// is idle, which the block itself does not enforce; cfg is always ready.
// The history is a row of HISTORY_DEPTH cells. A taken sample shifts into
// the row, then running min/max values walk down it one cell per cycle;
// its result waits for the whole walk, and an item that is not taken goes
// straight to the output. One item is in work at a time.
// Reset clears the history, the held window values, the peak, the burner
// flag and the last sample time, and restores register defaults.
// A stalled receiver holds the result in the output register; the block
// still takes the next item and finishes it, then waits until the output
// register is free.
module sliding_window_min_max_logger #(
	parameter int HISTORY_DEPTH = 128
) (
	input logic        clk,
	input logic        arst_n,
	swmm_stream_if.sink   samples,
	swmm_stream_if.source results,
	swmm_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	swmm_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]                  cnt_q;
	logic [swmm_pkg::INTERVAL_W-1:0]   interval_q;
	logic [swmm_pkg::TEMP_W-1:0]       thresh_q;
	logic [swmm_pkg::TIME_W-1:0]       last_time_q;
	logic [swmm_pkg::TEMP_W-1:0]       peak_q;
	logic [swmm_pkg::TEMP_W-1:0]       wmax_q;
	logic [swmm_pkg::TEMP_W-1:0]       wmin_q;
	logic                              burner_q;
	logic                              taken_q;
	logic                              out_valid_q;
	swmm_pkg::out_item_t               out_q;

	swmm_pkg::in_item_t                item;
	logic                              accept;
	logic                              take;
	logic [swmm_pkg::TIME_W-1:0]       elapsed;
	logic [swmm_pkg::TEMP_W-1:0]       peak_base;
	logic                              shift_en;
	logic                              scan_done;
	logic                              load_out;

	logic [swmm_pkg::TEMP_W-1:0] entry_w [HISTORY_DEPTH];
	swmm_pkg::link_t             link_w  [HISTORY_DEPTH+1];

	assign item   = samples.payload;
	assign accept = samples.valid && samples.ready;

	// sample decision: interval elapsed (wrapping) and read succeeded
	assign elapsed   = item.now_ms - last_time_q;
	assign take      = item.read_ok &&
	                   (elapsed >= swmm_pkg::TIME_W'(interval_q));
	assign peak_base = item.clear_peak ? '0 : peak_q;

	// cell row, head cell takes the new sample
	assign link_w[0].lo = '1;
	assign link_w[0].hi = '0;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		logic [swmm_pkg::TEMP_W-1:0] entry_src;
		if (i == 0) begin : g_head
			assign entry_src = item.temperature;
		end else begin : g_body
			assign entry_src = entry_w[i-1];
		end
		swmm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.entry_in (entry_src),
			.link_in  (link_w[i]),
			.entry_q  (entry_w[i]),
			.link_q   (link_w[i+1])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			swmm_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = take ? swmm_pkg::ST_SCAN : swmm_pkg::ST_OUT;
				end
			end
			swmm_pkg::ST_SCAN: begin
				if (cnt_q == CNT_W'(HISTORY_DEPTH)) begin
					state_d = swmm_pkg::ST_OUT;
				end
			end
			swmm_pkg::ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					state_d = swmm_pkg::ST_IDLE;
				end
			end
			default: state_d = swmm_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		samples.ready = 1'b0;
		shift_en      = 1'b0;
		scan_done     = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			swmm_pkg::ST_IDLE: begin
				samples.ready = 1'b1;
				shift_en      = samples.valid && take;
			end
			swmm_pkg::ST_SCAN: begin
				scan_done = (cnt_q == CNT_W'(HISTORY_DEPTH));
			end
			swmm_pkg::ST_OUT: begin
				load_out = !out_valid_q || results.ready;
			end
			default: ;
		endcase
	end

	assign cfg.ready       = 1'b1;
	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// control state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				cnt_q <= '0;
			end else if (state_q == swmm_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= swmm_pkg::INTERVAL_RST;
			thresh_q   <= swmm_pkg::THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.idx)
				swmm_pkg::CFG_SAMPLE_INTERVAL: interval_q <= cfg.data;
				swmm_pkg::CFG_BURNER_THRESH:   thresh_q <= cfg.data[swmm_pkg::TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// held logger state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			peak_q      <= '0;
			wmax_q      <= '0;
			wmin_q      <= '0;
			burner_q    <= 1'b0;
			taken_q     <= 1'b0;
		end else begin
			if (accept) begin
				taken_q <= take;
				peak_q  <= peak_base;
				if (take) begin
					last_time_q <= item.now_ms;
					burner_q    <= item.temperature > thresh_q;
					if (item.temperature > peak_base) begin
						peak_q <= item.temperature;
					end
				end
			end
			if (scan_done) begin
				wmax_q <= link_w[HISTORY_DEPTH].hi;
				wmin_q <= link_w[HISTORY_DEPTH].lo;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.sample_taken  <= taken_q;
			out_q.burner_active <= burner_q;
			out_q.latest_temp   <= entry_w[0];
			out_q.window_max    <= wmax_q;
			out_q.window_min    <= wmin_q;
			out_q.peak_temp     <= peak_q;
		end
	end

`ifndef SYNTHESIS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swmm_pkg::ST_SCAN |-> cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("scan counter past the end of the cell row");

	a_take_scans: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |=> state_q == swmm_pkg::ST_SCAN && cnt_q == '0)
		else $error("taken sample did not start a scan");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.window_min <= out_q.window_max)
		else $error("window minimum above window maximum");

	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.sample_taken |-> out_q.peak_temp >= out_q.latest_temp &&
		out_q.window_max >= out_q.latest_temp)
		else $error("taken sample above peak or window maximum");
`endif

endmodule

/* tb/swmm_result_checker.sv */
`timescale 1ns / 1ps
// checker that predicts logger results and compares them on each transfer
module swmm_result_checker #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  swmm_pkg::in_item_t              in_item,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  swmm_pkg::out_item_t             out_item,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [swmm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [swmm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);

	// predictor copy of registers and state
	logic [swmm_pkg::INTERVAL_W-1:0] interval_ms;
	logic [swmm_pkg::TEMP_W-1:0]     threshold;
	logic [swmm_pkg::TEMP_W-1:0]     temp_log [HISTORY_DEPTH];
	logic [swmm_pkg::TIME_W-1:0]     last_taken_ms;
	logic [swmm_pkg::TEMP_W-1:0]     peak;
	logic [swmm_pkg::TEMP_W-1:0]     win_max;
	logic [swmm_pkg::TEMP_W-1:0]     win_min;
	logic                            burner;

	swmm_pkg::out_item_t results_due [$];
	int                  error_count = 0;
	int                  due_count   = 0;

	assign errors  = error_count;
	assign pending = due_count;

	// apply one item to the predictor and return the result it should give
	function automatic swmm_pkg::out_item_t log_sample(input swmm_pkg::in_item_t it);
		swmm_pkg::out_item_t         res;
		logic [swmm_pkg::TIME_W-1:0] elapsed;
		logic [swmm_pkg::TEMP_W-1:0] hi;
		logic [swmm_pkg::TEMP_W-1:0] lo;
		logic                        taken;
		int                          k;
		taken = 1'b0;
		// peak clear happens before the sample decision
		if (it.clear_peak)
			peak = '0;
		elapsed = it.now_ms - last_taken_ms;
		if (it.read_ok && elapsed >= swmm_pkg::TIME_W'(interval_ms)) begin
			taken         = 1'b1;
			last_taken_ms = it.now_ms;
			burner        = it.temperature > threshold;
			for (k = HISTORY_DEPTH - 1; k > 0; k--)
				temp_log[k] = temp_log[k-1];
			temp_log[0] = it.temperature;
			// window covers every entry, zero-cleared ones too
			hi = it.temperature;
			lo = it.temperature;
			for (k = 1; k < HISTORY_DEPTH; k++) begin
				if (temp_log[k] > hi)
					hi = temp_log[k];
				if (temp_log[k] < lo)
					lo = temp_log[k];
			end
			win_max = hi;
			win_min = lo;
			if (it.temperature > peak)
				peak = it.temperature;
		end
		res.sample_taken  = taken;
		res.burner_active = burner;
		res.latest_temp   = temp_log[0];
		res.window_max    = win_max;
		res.window_min    = win_min;
		res.peak_temp     = peak;
		return res;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", field, want, got);
			error_count++;
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		swmm_pkg::out_item_t want;
		int                  k;
		if (!arst_n) begin
			interval_ms   = swmm_pkg::INTERVAL_RST;
			threshold     = swmm_pkg::THRESHOLD_RST;
			for (k = 0; k < HISTORY_DEPTH; k++)
				temp_log[k] = '0;
			last_taken_ms = '0;
			peak          = '0;
			win_max       = '0;
			win_min       = '0;
			burner        = 1'b0;
			results_due.delete();
		end else begin
			// register writes, unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (swmm_pkg::cfg_reg_t'(cfg_idx))
					swmm_pkg::CFG_SAMPLE_INTERVAL: interval_ms = cfg_data;
					swmm_pkg::CFG_BURNER_THRESH:
						threshold = cfg_data[swmm_pkg::TEMP_W-1:0];
					default: ;
				endcase
			end
			// result transfer against the oldest expectation
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no expectation waiting");
					error_count++;
				end else begin
					want = results_due.pop_front();
					check_field("sample_taken", 32'(want.sample_taken),
						32'(out_item.sample_taken));
					check_field("burner_active", 32'(want.burner_active),
						32'(out_item.burner_active));
					check_field("latest_temp", 32'(want.latest_temp),
						32'(out_item.latest_temp));
					check_field("window_max", 32'(want.window_max),
						32'(out_item.window_max));
					check_field("window_min", 32'(want.window_min),
						32'(out_item.window_min));
					check_field("peak_temp", 32'(want.peak_temp),
						32'(out_item.peak_temp));
				end
			end
			// sample transfer
			if (in_valid && in_ready)
				results_due.push_back(log_sample(in_item));
		end
		due_count = results_due.size();
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// top of the logger testbench: clock, reset, stimulus, result stalls and verdict
module tb_top;

	localparam int HIST_DEPTH       = 128;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int STALL_LIMIT      = 4000;
	localparam int PHASES           = 6;
	localparam int PHASE_ITEMS      = 180;
	localparam int HOLD_AFTER_ITEMS = 60;

	// indexes past the register list
	localparam logic [swmm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
	localparam logic [swmm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_HOLD
	} rx_mode_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	int                          items_sent  = 0;
	int                          idle_cycles = 0;
	int                          burst_left  = 0;
	logic [swmm_pkg::TIME_W-1:0] stamp_ms    = '0;
	int                          check_errors;
	int                          results_pending;

	swmm_stream_if #(.payload_t(swmm_pkg::in_item_t))  samples_if ();
	swmm_stream_if #(.payload_t(swmm_pkg::out_item_t)) results_if ();
	swmm_cfg_if                                        cfg_if ();

	sliding_window_min_max_logger #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg    (cfg_if)
	);

	swmm_result_checker #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples_if.valid),
		.in_ready (samples_if.ready),
		.in_item  (samples_if.payload),
		.out_valid(results_if.valid),
		.out_ready(results_if.ready),
		.out_item (results_if.payload),
		.cfg_valid(cfg_if.valid),
		.cfg_ready(cfg_if.ready),
		.cfg_idx  (cfg_if.idx),
		.cfg_data (cfg_if.data),
		.errors   (check_errors),
		.pending  (results_pending)
	);

	always #4 clk = ~clk;

	// transfer count and watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready)
				items_sent <= items_sent + 1;
			if ((samples_if.valid && samples_if.ready) ||
					(results_if.valid && results_if.ready) ||
					(cfg_if.valid && cfg_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// one sample item with given fields
	function automatic swmm_pkg::in_item_t pack_item(
			input logic [swmm_pkg::TIME_W-1:0] now, input logic ok,
			input logic [swmm_pkg::TEMP_W-1:0] temp, input logic clr);
		swmm_pkg::in_item_t it;
		it.now_ms      = now;
		it.read_ok     = ok;
		it.temperature = temp;
		it.clear_peak  = clr;
		return it;
	endfunction

	// random item, time steps mostly placed around the sample interval
	function automatic swmm_pkg::in_item_t make_item(
			input logic [swmm_pkg::INTERVAL_W-1:0] spacing,
			input logic [swmm_pkg::TEMP_W-1:0] thr);
		swmm_pkg::in_item_t          it;
		logic [swmm_pkg::TIME_W-1:0] step;
		int unsigned                 pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			step = '0;
		else if (pick < 20)
			step = swmm_pkg::TIME_W'(spacing) - 1'b1;
		else if (pick < 45)
			step = swmm_pkg::TIME_W'(spacing);
		else if (pick < 55)
			step = swmm_pkg::TIME_W'(spacing) + 1'b1;
		else if (pick < 96)
			step = $urandom_range(0, 2 * int'(spacing) + 2);
		else
			step = $urandom();
		stamp_ms       = stamp_ms + step;
		it.now_ms      = stamp_ms;
		it.read_ok     = $urandom_range(0, 99) < 85;
		it.clear_peak  = $urandom_range(0, 99) < 8;
		pick           = $urandom_range(0, 99);
		if (pick < 8)
			it.temperature = '0;
		else if (pick < 16)
			it.temperature = '1;
		else if (pick < 30)
			it.temperature = thr + swmm_pkg::TEMP_W'($urandom_range(0, 2)) - 1'b1;
		else
			it.temperature = swmm_pkg::TEMP_W'($urandom_range(0, 2047));
		return it;
	endfunction

	// offer one item, bursts with random gaps between them
	task automatic offer(input swmm_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				samples_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		samples_if.valid   <= 1'b1;
		samples_if.payload <= it;
		do @(posedge clk); while (!samples_if.ready);
		@(negedge clk);
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		samples_if.valid <= 1'b0;
		burst_left = 0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [swmm_pkg::CFG_IDX_W-1:0] idx,
			input logic [swmm_pkg::CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.idx   <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// result side stalls, at least one long hold while the input keeps coming
	initial begin : receiver
		rx_mode_t mode;
		int       seg_len;
		bit       held_once;
		held_once        = 1'b0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_once && items_sent >= HOLD_AFTER_ITEMS) begin
				held_once = 1'b1;
				mode      = RX_HOLD;
			end else begin
				mode = rx_mode_t'($urandom_range(RX_FREE, RX_HOLD));
				if (mode == RX_HOLD && $urandom_range(0, 7) != 0)
					mode = RX_COIN;
			end
			seg_len = (mode == RX_HOLD) ? LONG_HOLD_CYCLES : $urandom_range(20, 300);
			repeat (seg_len) begin
				@(negedge clk);
				case (mode)
					RX_FREE:   results_if.ready <= 1'b1;
					RX_COIN:   results_if.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: results_if.ready <= ($urandom_range(0, 3) == 0);
					default:   results_if.ready <= 1'b0;
				endcase
			end
		end
	end

	// reset, directed items, then random phases under several settings
	initial begin : stimulus
		logic [swmm_pkg::INTERVAL_W-1:0] spacing;
		logic [swmm_pkg::TEMP_W-1:0]     thr;
		logic [swmm_pkg::CFG_DATA_W-1:0] thr_word;
		int                              ph;
		samples_if.valid   = 1'b0;
		samples_if.payload = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.idx         = swmm_pkg::CFG_SAMPLE_INTERVAL;
		cfg_if.data        = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: interval check, read failure, threshold edge, clears
		offer(pack_item(32'd0, 1'b1, 11'd50, 1'b0));
		offer(pack_item(32'd999, 1'b1, 11'd60, 1'b0));
		offer(pack_item(32'd1000, 1'b1, 11'd2047, 1'b0));
		offer(pack_item(32'd2000, 1'b0, 11'd500, 1'b0));
		offer(pack_item(32'd2001, 1'b1, 11'd100, 1'b0));
		offer(pack_item(32'd3001, 1'b1, 11'd101, 1'b1));
		offer(pack_item(32'd3002, 1'b1, 11'd0, 1'b1));
		offer(pack_item(32'd4001, 1'b1, 11'd0, 1'b0));
		// time stamp wrap
		offer(pack_item(32'hFFFF_FFFF, 1'b1, 11'd1234, 1'b0));
		offer(pack_item(32'd742, 1'b1, 11'd5, 1'b0));
		offer(pack_item(32'd999, 1'b1, 11'd6, 1'b0));
		offer(pack_item(32'd999, 1'b1, 11'd7, 1'b0));

		// zero interval, top threshold with upper data bits set, spare indexes
		drain();
		write_reg(swmm_pkg::CFG_SAMPLE_INTERVAL, '0);
		write_reg(swmm_pkg::CFG_BURNER_THRESH, '1);
		write_reg(CFG_IDX_SPARE_A, '0);
		write_reg(CFG_IDX_SPARE_B, '1);
		offer(pack_item(32'd999, 1'b1, 11'd2047, 1'b0));
		offer(pack_item(32'd5, 1'b0, 11'd3, 1'b1));
		offer(pack_item(32'd5, 1'b1, 11'd3, 1'b0));

		// largest interval, zero threshold
		drain();
		write_reg(swmm_pkg::CFG_SAMPLE_INTERVAL, '1);
		write_reg(swmm_pkg::CFG_BURNER_THRESH, '0);
		offer(pack_item(32'd65540, 1'b1, 11'd1, 1'b0));
		offer(pack_item(32'd65541, 1'b1, 11'd0, 1'b0));
		offer(pack_item(32'd131074, 1'b1, 11'd0, 1'b0));
		offer(pack_item(32'd131075, 1'b1, 11'd0, 1'b0));
		stamp_ms = 32'd131075;

		// random phases
		for (ph = 0; ph < PHASES; ph++) begin
			thr = swmm_pkg::TEMP_W'($urandom_range(0, 2047));
			case (ph)
				0:       spacing = '0;
				1: begin
					spacing = 16'd1;
					thr     = '0;
				end
				2: begin
					spacing  = '1;
					thr      = '1;
					stamp_ms = 32'hFFFF_0000;
				end
				3: begin
					spacing = swmm_pkg::INTERVAL_RST;
					thr     = swmm_pkg::THRESHOLD_RST;
				end
				4:       spacing = swmm_pkg::INTERVAL_W'($urandom_range(2, 5000));
				default: spacing = '0;
			endcase
			thr_word                       = swmm_pkg::CFG_DATA_W'($urandom());
			thr_word[swmm_pkg::TEMP_W-1:0] = thr;
			drain();
			write_reg(swmm_pkg::CFG_SAMPLE_INTERVAL, spacing);
			write_reg(swmm_pkg::CFG_BURNER_THRESH, thr_word);
			write_reg(ph[0] ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
				swmm_pkg::CFG_DATA_W'($urandom()));
			repeat (PHASE_ITEMS) offer(make_item(spacing, thr));
		end

		// wait out the last results and the block's own latency
		drain();
		repeat (HIST_DEPTH + 8) @(negedge clk);
		if (check_errors == 0 && results_pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
